### sv/iaf_pkg.sv
package iaf_pkg;

  // field widths
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned DWORD_W = 2 * WORD_W;
  localparam int unsigned CNT_W   = $clog2(DWORD_W);

  // largest quotient magnitudes for a positive and for a negative result
  localparam logic [DWORD_W-1:0] QUOT_POS_MAX = DWORD_W'(32767);
  localparam logic [DWORD_W-1:0] QUOT_NEG_MAX = DWORD_W'(32768);

  // operation codes
  typedef enum logic [2:0] {
    MODE_ADD16 = 3'd0,
    MODE_SUB16 = 3'd1,
    MODE_NEG16 = 3'd2,
    MODE_ADD32 = 3'd3,
    MODE_SUB32 = 3'd4,
    MODE_MUL   = 3'd5,
    MODE_DIV   = 3'd6,
    MODE_CMP   = 3'd7
  } mode_e;

  // interrupt codes
  typedef enum logic [1:0] {
    IRQ_NONE     = 2'd0,
    IRQ_DIV_ZERO = 2'd1,
    IRQ_DIV_OVF  = 2'd2
  } irq_e;

  // control state, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // input item
  typedef struct packed {
    mode_e             mode;
    logic [WORD_W-1:0] acc_hi;
    logic [WORD_W-1:0] acc_lo;
    logic [WORD_W-1:0] arg_hi;
    logic [WORD_W-1:0] arg_lo;
    logic              carry_in;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [WORD_W-1:0] result_hi;
    logic [WORD_W-1:0] result_lo;
    logic              write_back;
    irq_e              interrupt_code;
    logic              flag_z;
    logic              flag_m;
    logic              flag_v;
    logic              flag_c;
    logic              flag_l;
    logic              flag_e;
    logic              flag_g;
  } out_item_t;

  // persistent flags
  typedef struct packed {
    logic z;
    logic m;
    logic v;
    logic c;
    logic l;
    logic e;
    logic g;
  } flags_t;

  // set-up of the bit-serial adder
  typedef struct packed {
    logic [DWORD_W-1:0] x;      // first operand
    logic [DWORD_W-1:0] b;      // second operand before negation
    logic               neg;    // negate b on the fly
    logic               cin;    // increment added to b after any negation
    logic               len32;  // 32 bits instead of 16
  } add_cfg_t;

  // what the bit-serial adder leaves behind
  typedef struct packed {
    logic [DWORD_W-1:0] sum;   // sum bits, msb aligned
    logic               xa;    // top bit of x
    logic               yb;    // top bit of the addend
    logic               zs;    // top bit of the sum
    logic               c;     // carry out of the top bit
    logic               yc;    // carry out of the addend increment
    logic               nz;    // any sum bit set
    logic               nzab;  // any operand bit set
    logic               lt;    // signed x less than b
    logic               ne;    // x differs from b
  } add_stat_t;

  // set-up of the multiply / divide unit
  typedef struct packed {
    logic              div;
    logic [WORD_W-1:0] a_hi;
    logic [WORD_W-1:0] a_lo;
    logic [WORD_W-1:0] b_lo;
  } md_cfg_t;

  // result of the multiply / divide unit
  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    logic              zero;
    logic              minus;
    logic              dz;    // divisor is zero
    logic              ovf;   // quotient out of range
  } md_stat_t;

endpackage

### sv/integer_alu_with_flags_top.sv
// Integer ALU with a persistent flag set (Z, M, V, C and the compare flags
// L, E, G). One item in gives one item out; the item carries the flags as they
// stand after the operation. Items are handled one at a time. Add16, sub16,
// neg16 and compare run through a bit-serial adder, one bit per cycle, as do
// add32 and sub32. Multiply runs a shift-add over one multiplier bit per cycle;
// divide is a restoring divide over one quotient bit per cycle. A finished
// item sits in the output register, so a new item is taken while it waits,
// but the next result is held back until it has been taken. Divide by zero
// or quotient overflow reports an interrupt code, writes nothing back and
// leaves all flags alone.
module integer_alu_with_flags_top import iaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e    st_q, st_d;
  mode_e     mode_q;
  flags_t    fl_q, fl_d;
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic      accept;
  logic      finish;
  logic      start_add, start_md;
  logic      add_busy, md_busy;
  add_cfg_t  add_cfg;
  add_stat_t add_st;
  md_cfg_t   md_cfg;
  md_stat_t  md_st;
  logic      ov;
  logic      c16;

  assign in_stall_o = (st_q != ST_IDLE);
  assign accept     = in_valid_i && (st_q == ST_IDLE);
  assign finish     = (st_q == ST_RUN) && !add_busy && !md_busy &&
                      (!out_valid_q || !out_stall_i);

  // route the item to one of the two units
  always_comb begin
    add_cfg.x     = {{WORD_W{1'b0}}, in_item_i.acc_lo};
    add_cfg.b     = {{WORD_W{1'b0}}, in_item_i.arg_lo};
    add_cfg.neg   = 1'b0;
    add_cfg.cin   = 1'b0;
    add_cfg.len32 = 1'b0;
    start_add     = 1'b0;
    start_md      = 1'b0;
    unique case (in_item_i.mode)
      MODE_ADD16: begin
        add_cfg.cin = in_item_i.carry_in;
        start_add   = accept;
      end
      MODE_SUB16: begin
        add_cfg.neg = 1'b1;
        add_cfg.cin = in_item_i.carry_in;
        start_add   = accept;
      end
      MODE_NEG16: begin
        add_cfg.x   = {{WORD_W{1'b0}}, ~in_item_i.acc_lo};
        add_cfg.b   = '0;
        add_cfg.cin = in_item_i.carry_in;
        start_add   = accept;
      end
      MODE_ADD32: begin
        add_cfg.x     = {in_item_i.acc_hi, in_item_i.acc_lo};
        add_cfg.b     = {in_item_i.arg_hi, in_item_i.arg_lo};
        add_cfg.len32 = 1'b1;
        start_add     = accept;
      end
      MODE_SUB32: begin
        add_cfg.x     = {in_item_i.acc_hi, in_item_i.acc_lo};
        add_cfg.b     = {in_item_i.arg_hi, in_item_i.arg_lo};
        add_cfg.neg   = 1'b1;
        add_cfg.len32 = 1'b1;
        start_add     = accept;
      end
      MODE_MUL, MODE_DIV: begin
        start_md = accept;
      end
      MODE_CMP: begin
        start_add = accept;
      end
      default: begin
        start_add = 1'b0;
      end
    endcase
    md_cfg.div  = (in_item_i.mode == MODE_DIV);
    md_cfg.a_hi = in_item_i.acc_hi;
    md_cfg.a_lo = in_item_i.acc_lo;
    md_cfg.b_lo = in_item_i.arg_lo;
  end

  iaf_addser u_addser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_add),
    .cfg_i   (add_cfg),
    .busy_o  (add_busy),
    .stat_o  (add_st)
  );

  iaf_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_md),
    .cfg_i   (md_cfg),
    .busy_o  (md_busy),
    .stat_o  (md_st)
  );

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept) begin
        st_d = ST_RUN;
      end
      ST_RUN: if (finish) begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // flags and result item from the unit that ran
  always_comb begin
    fl_d = fl_q;
    ov   = (add_st.xa & add_st.yb & !add_st.zs) | (!add_st.xa & !add_st.yb & add_st.zs);
    c16  = add_st.c | add_st.yc;
    out_d.result_hi      = '0;
    out_d.result_lo      = '0;
    out_d.write_back     = 1'b0;
    out_d.interrupt_code = IRQ_NONE;
    unique case (mode_q)
      MODE_ADD16, MODE_SUB16, MODE_NEG16: begin
        fl_d.v = ov;
        fl_d.m = add_st.zs ^ ov;
        fl_d.c = c16;
        fl_d.z = !add_st.nz && (!c16 || !ov);
        // zero minus zero sets carry after zero is settled
        if (mode_q == MODE_SUB16 && !add_st.nzab) begin
          fl_d.c = 1'b1;
        end
        out_d.result_lo  = add_st.sum[DWORD_W-1:WORD_W];
        out_d.write_back = 1'b1;
      end
      MODE_ADD32, MODE_SUB32: begin
        fl_d.v = fl_q.v | ov;
        fl_d.m = add_st.zs ^ ov;
        fl_d.c = add_st.c;
        fl_d.z = !add_st.nz;
        out_d.result_hi  = add_st.sum[DWORD_W-1:WORD_W];
        out_d.result_lo  = add_st.sum[WORD_W-1:0];
        out_d.write_back = 1'b1;
      end
      MODE_MUL: begin
        fl_d.z = md_st.zero;
        fl_d.m = md_st.minus;
        out_d.result_hi  = md_st.hi;
        out_d.result_lo  = md_st.lo;
        out_d.write_back = 1'b1;
      end
      MODE_DIV: begin
        priority if (md_st.dz) begin
          out_d.interrupt_code = IRQ_DIV_ZERO;
        end else if (md_st.ovf) begin
          out_d.interrupt_code = IRQ_DIV_OVF;
        end else begin
          fl_d.z = md_st.zero;
          fl_d.m = md_st.minus;
          out_d.result_hi  = md_st.hi;
          out_d.result_lo  = md_st.lo;
          out_d.write_back = 1'b1;
        end
      end
      MODE_CMP: begin
        fl_d.l = add_st.lt;
        fl_d.e = !add_st.ne;
        fl_d.g = add_st.ne && !add_st.lt;
      end
      default: begin
        fl_d = fl_q;
      end
    endcase
    out_d.flag_z = fl_d.z;
    out_d.flag_m = fl_d.m;
    out_d.flag_v = fl_d.v;
    out_d.flag_c = fl_d.c;
    out_d.flag_l = fl_d.l;
    out_d.flag_e = fl_d.e;
    out_d.flag_g = fl_d.g;
  end

  // control state, flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      fl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (finish) begin
        fl_q        <= fl_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item mode and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_item_i.mode;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_idle_units_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !(add_busy || md_busy))
    else $error("unit busy while no item is in flight");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(add_busy && md_busy))
    else $error("both units busy at once");

  a_cmp_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({fl_q.l, fl_q.e, fl_q.g}))
    else $error("more than one compare flag set");

  a_irq_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.interrupt_code != IRQ_NONE) |->
      (!out_q.write_back && out_q.result_hi == '0 && out_q.result_lo == '0))
    else $error("interrupt item carries a write back");
`endif

endmodule

### sv/iaf_addser.sv
module iaf_addser import iaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  add_cfg_t  cfg_i,
  output logic      busy_o,
  output add_stat_t stat_o
);

  localparam logic [CNT_W-1:0] LAST16 = CNT_W'(WORD_W - 1);
  localparam logic [CNT_W-1:0] LAST32 = CNT_W'(DWORD_W - 1);

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               len32_q;
  logic               neg_q;
  logic [DWORD_W-1:0] x_q;
  logic [DWORD_W-1:0] b_q;
  logic [DWORD_W-1:0] s_q;
  logic               nc_q;
  logic               ic_q;
  logic               c_q;
  logic               nz_q;
  logic               nzab_q;
  logic               lt_q;
  logic               ne_q;
  logic               xa_q;
  logic               yb_q;
  logic               zs_q;

  logic xi, braw, bi, ni, yi, si, last, differ;

  // one bit of negate, increment and add per cycle, lsb first
  always_comb begin
    xi     = x_q[0];
    braw   = b_q[0];
    bi     = braw ^ neg_q;
    ni     = bi ^ nc_q;
    yi     = ni ^ ic_q;
    si     = xi ^ yi ^ c_q;
    differ = xi ^ braw;
    last   = (cnt_q == (len32_q ? LAST32 : LAST16));
  end

  // bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operand shift registers and running status
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q     <= cfg_i.x;
      b_q     <= cfg_i.b;
      s_q     <= '0;
      neg_q   <= cfg_i.neg;
      len32_q <= cfg_i.len32;
      nc_q    <= cfg_i.neg;
      ic_q    <= cfg_i.cin;
      c_q     <= 1'b0;
      nz_q    <= 1'b0;
      nzab_q  <= 1'b0;
      lt_q    <= 1'b0;
      ne_q    <= 1'b0;
    end else if (busy_q) begin
      x_q    <= {1'b0, x_q[DWORD_W-1:1]};
      b_q    <= {1'b0, b_q[DWORD_W-1:1]};
      s_q    <= {si, s_q[DWORD_W-1:1]};
      nc_q   <= bi & nc_q;
      ic_q   <= ni & ic_q;
      c_q    <= (xi & yi) | (c_q & (xi ^ yi));
      nz_q   <= nz_q | si;
      nzab_q <= nzab_q | xi | braw;
      ne_q   <= ne_q | differ;
      // the highest differing bit decides; on the sign bit the sense flips
      if (differ) begin
        lt_q <= last ? xi : braw;
      end
      if (last) begin
        xa_q <= xi;
        yb_q <= yi;
        zs_q <= si;
      end
    end
  end

  assign busy_o      = busy_q;
  assign stat_o.sum  = s_q;
  assign stat_o.xa   = xa_q;
  assign stat_o.yb   = yb_q;
  assign stat_o.zs   = zs_q;
  assign stat_o.c    = c_q;
  assign stat_o.yc   = ic_q;
  assign stat_o.nz   = nz_q;
  assign stat_o.nzab = nzab_q;
  assign stat_o.lt   = lt_q;
  assign stat_o.ne   = ne_q;

endmodule

### sv/iaf_muldiv.sv
module iaf_muldiv import iaf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  md_cfg_t  cfg_i,
  output logic     busy_o,
  output md_stat_t stat_o
);

  localparam logic [CNT_W-1:0] LAST16 = CNT_W'(WORD_W - 1);
  localparam logic [CNT_W-1:0] LAST32 = CNT_W'(DWORD_W - 1);
  localparam int unsigned      SUM_W  = WORD_W + 2;

  logic               busy_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               div_q;
  logic               dneg_q;
  logic               vneg_q;
  logic [WORD_W-1:0]  opa_q;
  logic [WORD_W:0]    acc_q;
  logic [DWORD_W-1:0] w_q;

  logic               last;
  logic               sub;
  logic               qbit;
  logic [SUM_W-1:0]   add_a;
  logic [SUM_W-1:0]   add_b;
  logic [SUM_W-1:0]   sum;
  logic [DWORD_W-1:0] dividend;
  logic [DWORD_W-1:0] prod;
  logic               qneg;

  // shared 18-bit adder: shift-add step or restoring divide step
  always_comb begin
    last = (cnt_q == (div_q ? LAST32 : LAST16));
    if (div_q) begin
      add_a = {1'b0, acc_q[WORD_W-1:0], w_q[DWORD_W-1]};
      add_b = {2'b00, opa_q};
      sub   = 1'b1;
    end else begin
      add_a = {acc_q[WORD_W], acc_q};
      add_b = w_q[0] ? {{2{opa_q[WORD_W-1]}}, opa_q} : '0;
      sub   = last;
    end
    sum  = add_a + (sub ? ~add_b : add_b) + SUM_W'(sub);
    qbit = !sum[SUM_W-1];
  end

  assign dividend = {cfg_i.a_hi, cfg_i.a_lo};

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // divide operands are loaded as magnitudes, multiply operands as they stand
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= cfg_i.div;
      dneg_q <= cfg_i.a_hi[WORD_W-1];
      vneg_q <= cfg_i.b_lo[WORD_W-1];
      acc_q  <= '0;
      if (cfg_i.div) begin
        opa_q <= cfg_i.b_lo[WORD_W-1] ? WORD_W'(0) - cfg_i.b_lo : cfg_i.b_lo;
        w_q   <= cfg_i.a_hi[WORD_W-1] ? DWORD_W'(0) - dividend : dividend;
      end else begin
        opa_q <= cfg_i.a_lo;
        w_q   <= {{WORD_W{1'b0}}, cfg_i.b_lo};
      end
    end else if (busy_q) begin
      if (div_q) begin
        acc_q <= {1'b0, qbit ? sum[WORD_W-1:0] : add_a[WORD_W-1:0]};
        w_q   <= {w_q[DWORD_W-2:0], qbit};
      end else begin
        acc_q <= sum[SUM_W-1:1];
        w_q   <= {w_q[DWORD_W-1:WORD_W], sum[0], w_q[WORD_W-1:1]};
      end
    end
  end

  // final product, or quotient and remainder with their signs restored
  always_comb begin
    prod = {acc_q[WORD_W-1:0], w_q[WORD_W-1:0]};
    qneg = dneg_q ^ vneg_q;
    stat_o.dz  = (opa_q == '0);
    stat_o.ovf = qneg ? (w_q > QUOT_NEG_MAX) : (w_q > QUOT_POS_MAX);
    if (div_q) begin
      stat_o.lo    = qneg ? WORD_W'(0) - w_q[WORD_W-1:0] : w_q[WORD_W-1:0];
      stat_o.hi    = dneg_q ? WORD_W'(0) - acc_q[WORD_W-1:0] : acc_q[WORD_W-1:0];
      stat_o.zero  = (w_q[WORD_W-1:0] == '0);
      stat_o.minus = qneg && (w_q[WORD_W-1:0] != '0);
    end else begin
      stat_o.hi    = prod[DWORD_W-1:WORD_W];
      stat_o.lo    = prod[WORD_W-1:0];
      stat_o.zero  = (prod == '0);
      stat_o.minus = prod[DWORD_W-1];
    end
  end

  assign busy_o = busy_q;

endmodule

### verif/alu_flag_checker.sv
module alu_flag_checker import iaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        mismatch_count_o,
  output int        pending_count_o,
  output int        checked_count_o
);

  localparam longint QUOT_MAX = 32767;
  localparam longint QUOT_MIN = -32768;

  flags_t    flags_q;
  out_item_t expected_q[$];
  out_item_t want;
  int        mismatches;
  int        checked;

  assign mismatch_count_o = mismatches;
  assign checked_count_o  = checked;

  // works out the result of one item and moves the flag set along
  function automatic out_item_t alu_result(in_item_t it);
    out_item_t          r;
    logic [15:0]        b16;
    logic [16:0]        y;
    logic [16:0]        s;
    logic [15:0]        na;
    logic [15:0]        ns;
    logic [31:0]        a32;
    logic [31:0]        b32;
    logic [32:0]        s33;
    logic               ov;
    logic signed [31:0] prod;
    longint             dividend;
    longint             divisor;
    longint             quo;
    longint             rem;
    r = '0;
    r.interrupt_code = IRQ_NONE;
    case (it.mode)
      MODE_ADD16, MODE_SUB16: begin
        b16 = (it.mode == MODE_SUB16) ? 16'h0 - it.arg_lo : it.arg_lo;
        y = {1'b0, b16} + 17'(it.carry_in);
        s = {1'b0, it.acc_lo} + y;
        flags_q.v = (it.acc_lo[15] & y[15] & ~s[15]) | (~it.acc_lo[15] & ~y[15] & s[15]);
        flags_q.m = s[15] ^ flags_q.v;
        flags_q.c = s[16];
        flags_q.z = (s[15:0] == 16'h0) && (!flags_q.c || !flags_q.v);
        // zero minus zero forces the carry, after z is settled
        if (it.mode == MODE_SUB16 && it.acc_lo == 16'h0 && it.arg_lo == 16'h0) begin
          flags_q.c = 1'b1;
        end
        r.result_lo  = s[15:0];
        r.write_back = 1'b1;
      end
      MODE_NEG16: begin
        na = ~it.acc_lo;
        ns = na + 16'(it.carry_in);
        flags_q.v = ~na[15] & ns[15];
        flags_q.m = ns[15] ^ flags_q.v;
        flags_q.c = (it.acc_lo == 16'h0) && it.carry_in;
        flags_q.z = (ns == 16'h0) && (!flags_q.c || !flags_q.v);
        r.result_lo  = ns;
        r.write_back = 1'b1;
      end
      MODE_ADD32, MODE_SUB32: begin
        a32 = {it.acc_hi, it.acc_lo};
        b32 = {it.arg_hi, it.arg_lo};
        if (it.mode == MODE_SUB32) begin
          b32 = 32'h0 - b32;
        end
        s33 = {1'b0, a32} + {1'b0, b32};
        ov = (a32[31] & b32[31] & ~s33[31]) | (~a32[31] & ~b32[31] & s33[31]);
        // overflow is sticky here
        if (ov) begin
          flags_q.v = 1'b1;
        end
        flags_q.m = s33[31] ^ ov;
        flags_q.c = s33[32];
        flags_q.z = (s33[31:0] == 32'h0);
        r.result_hi  = s33[31:16];
        r.result_lo  = s33[15:0];
        r.write_back = 1'b1;
      end
      MODE_MUL: begin
        prod = $signed({{16{it.acc_lo[15]}}, it.acc_lo})
             * $signed({{16{it.arg_lo[15]}}, it.arg_lo});
        flags_q.m = prod[31];
        flags_q.z = (prod == 32'sh0);
        r.result_hi  = prod[31:16];
        r.result_lo  = prod[15:0];
        r.write_back = 1'b1;
      end
      MODE_DIV: begin
        divisor  = longint'($signed(it.arg_lo));
        dividend = longint'($signed({it.acc_hi, it.acc_lo}));
        if (divisor == 0) begin
          r.interrupt_code = IRQ_DIV_ZERO;
        end else begin
          quo = dividend / divisor;
          rem = dividend % divisor;
          if (quo > QUOT_MAX || quo < QUOT_MIN) begin
            r.interrupt_code = IRQ_DIV_OVF;
          end else begin
            flags_q.m = (quo < 0);
            flags_q.z = (quo == 0);
            r.result_hi  = rem[15:0];
            r.result_lo  = quo[15:0];
            r.write_back = 1'b1;
          end
        end
      end
      default: begin
        flags_q.l = ($signed(it.acc_lo) < $signed(it.arg_lo));
        flags_q.e = (it.acc_lo == it.arg_lo);
        flags_q.g = ($signed(it.acc_lo) > $signed(it.arg_lo));
      end
    endcase
    r.flag_z = flags_q.z;
    r.flag_m = flags_q.m;
    r.flag_v = flags_q.v;
    r.flag_c = flags_q.c;
    r.flag_l = flags_q.l;
    r.flag_e = flags_q.e;
    r.flag_g = flags_q.g;
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // result side first, then queue the prediction for a newly taken item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result item arrived with nothing outstanding");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          compare_field("result_hi", want.result_hi, out_item_i.result_hi);
          compare_field("result_lo", want.result_lo, out_item_i.result_lo);
          compare_field("write_back", 16'(want.write_back), 16'(out_item_i.write_back));
          compare_field("interrupt_code", 16'(want.interrupt_code),
                        16'(out_item_i.interrupt_code));
          compare_field("flag_z", 16'(want.flag_z), 16'(out_item_i.flag_z));
          compare_field("flag_m", 16'(want.flag_m), 16'(out_item_i.flag_m));
          compare_field("flag_v", 16'(want.flag_v), 16'(out_item_i.flag_v));
          compare_field("flag_c", 16'(want.flag_c), 16'(out_item_i.flag_c));
          compare_field("flag_l", 16'(want.flag_l), 16'(out_item_i.flag_l));
          compare_field("flag_e", 16'(want.flag_e), 16'(out_item_i.flag_e));
          compare_field("flag_g", 16'(want.flag_g), 16'(out_item_i.flag_g));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(alu_result(in_item_i));
      end
    end
    pending_count_o = expected_q.size();
  end

endmodule

### verif/tb_integer_alu_with_flags_top.sv
module tb_integer_alu_with_flags_top;
  import iaf_pkg::*;

  localparam int STUCK_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_ITEMS    = 20;
  localparam int PHASE_ITEMS   = 370;
  localparam int TAIL_CYCLES   = 40;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;
  int stuck_cycles;
  int tx_gap_pct;
  int rx_stall_pct;
  int sent_cnt;
  int mode_cnt[8];
  bit hold_flip;

  integer_alu_with_flags_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  alu_flag_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_cnt),
    .pending_count_o  (pending_cnt),
    .checked_count_o  (checked_cnt)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_integer_alu_with_flags_top NOT OK");
      $finish;
    end
  end

  // result side stall, with a long hold-off each time hold_flip toggles
  initial begin
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  function automatic in_item_t make_item(mode_e mode, logic [15:0] acc_hi,
                                         logic [15:0] acc_lo, logic [15:0] arg_hi,
                                         logic [15:0] arg_lo, logic carry_in);
    in_item_t it;
    it.mode     = mode;
    it.acc_hi   = acc_hi;
    it.acc_lo   = acc_lo;
    it.arg_hi   = arg_hi;
    it.arg_lo   = arg_lo;
    it.carry_in = carry_in;
    return it;
  endfunction

  // operand word, leaning on the corners of the 16-bit range
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'h0001;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    logic [15:0] w;
    int          quo;
    int          dvs;
    int          rmag;
    int          dvd;
    it = make_item(mode_e'(3'($urandom_range(0, 7))), pick_word(), pick_word(),
                   pick_word(), pick_word(), 1'($urandom_range(0, 1)));
    // most divides are built from a quotient that fits, so they complete
    if (it.mode == MODE_DIV && $urandom_range(0, 99) < 70) begin
      w = pick_word();
      dvs = int'($signed(w));
      if (dvs == 0) begin
        dvs = 1;
      end
      if ($urandom_range(0, 1) == 1) begin
        quo = int'($urandom_range(0, 40)) - 20;
      end else begin
        quo = int'($urandom_range(0, 65535)) - 32768;
      end
      dvd = quo * dvs;
      rmag = $urandom_range(0, ((dvs < 0) ? -dvs : dvs) - 1);
      if (dvd < 0 || (dvd == 0 && $urandom_range(0, 1) == 1)) begin
        dvd = dvd - rmag;
      end else begin
        dvd = dvd + rmag;
      end
      it.arg_lo = 16'(dvs);
      {it.acc_hi, it.acc_lo} = dvd;
    end
    if (it.mode == MODE_CMP && $urandom_range(0, 3) == 0) begin
      it.arg_lo = it.acc_lo;
    end
    return it;
  endfunction

  // offer one item and hold it until taken
  task automatic send_item(in_item_t it);
    bit stalled;
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    sent_cnt++;
    mode_cnt[it.mode]++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending_cnt != 0) begin
      @(negedge clk_i);
    end
    @(posedge clk_i);
  endtask

  initial begin
    int gap_profile[4];
    int stall_profile[4];
    gap_profile   = '{0, 49, 0, 18};
    stall_profile = '{0, 0, 49, 18};
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    hold_flip    = 1'b0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corner cases of every operation
    send_item(make_item(MODE_ADD16, 16'h0, 16'h7FFF, 16'h0, 16'h0001, 1'b0));
    send_item(make_item(MODE_ADD16, 16'h0, 16'hFFFF, 16'h0, 16'h0001, 1'b0));
    send_item(make_item(MODE_ADD16, 16'h0, 16'h8000, 16'h0, 16'h8000, 1'b0));
    send_item(make_item(MODE_ADD16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(make_item(MODE_SUB16, 16'h0, 16'h0000, 16'h0, 16'h0000, 1'b0));
    send_item(make_item(MODE_SUB16, 16'h0, 16'h8000, 16'h0, 16'h0001, 1'b0));
    send_item(make_item(MODE_SUB16, 16'h0, 16'h0005, 16'h0, 16'h0005, 1'b1));
    send_item(make_item(MODE_NEG16, 16'h0, 16'h0000, 16'h0, 16'h0, 1'b1));
    send_item(make_item(MODE_NEG16, 16'h0, 16'h8000, 16'h0, 16'h0, 1'b1));
    send_item(make_item(MODE_NEG16, 16'h0, 16'hFFFF, 16'h0, 16'h0, 1'b0));
    send_item(make_item(MODE_ADD32, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 1'b0));
    // overflow flag must survive a clean 32-bit add
    send_item(make_item(MODE_ADD32, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 1'b0));
    send_item(make_item(MODE_ADD32, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 1'b0));
    send_item(make_item(MODE_SUB32, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 1'b0));
    send_item(make_item(MODE_SUB32, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(make_item(MODE_MUL, 16'h0, 16'h8000, 16'h0, 16'h8000, 1'b0));
    send_item(make_item(MODE_MUL, 16'h0, 16'h7FFF, 16'h0, 16'h8000, 1'b0));
    send_item(make_item(MODE_MUL, 16'h0, 16'hFFFF, 16'h0, 16'h0000, 1'b0));
    send_item(make_item(MODE_DIV, 16'h1234, 16'h5678, 16'h0, 16'h0000, 1'b0));
    send_item(make_item(MODE_DIV, 16'h8000, 16'h0000, 16'h0, 16'hFFFF, 1'b0));
    send_item(make_item(MODE_DIV, 16'h0001, 16'h0000, 16'h0, 16'h0001, 1'b0));
    send_item(make_item(MODE_DIV, 16'hFFFF, 16'h8000, 16'h0, 16'h0001, 1'b0));
    send_item(make_item(MODE_DIV, 16'hFFFF, 16'hFFF9, 16'h0, 16'h0002, 1'b0));
    send_item(make_item(MODE_DIV, 16'h0000, 16'h0007, 16'h0, 16'hFFFE, 1'b0));
    send_item(make_item(MODE_CMP, 16'h0, 16'h8000, 16'h0, 16'h7FFF, 1'b0));
    send_item(make_item(MODE_CMP, 16'h0, 16'h1234, 16'h0, 16'h1234, 1'b0));
    send_item(make_item(MODE_CMP, 16'h0, 16'h7FFF, 16'h0, 16'h8000, 1'b0));
    wait_drained();

    // random items under each idling profile
    for (int p = 0; p < 4; p++) begin
      tx_gap_pct   = gap_profile[p];
      rx_stall_pct = stall_profile[p];
      if (p == 0) begin
        // output held off while items keep coming, backs up into the input
        hold_flip = ~hold_flip;
        for (int i = 0; i < HOLD_ITEMS; i++) begin
          send_item(random_item());
        end
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item());
      end
      wait_drained();
    end

    rx_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d items (add16 %0d sub16 %0d neg16 %0d add32 %0d sub32 %0d",
             sent_cnt, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3], mode_cnt[4]);
    $display("mul %0d div %0d cmp %0d), %0d results checked, four idle profiles, long hold",
             mode_cnt[5], mode_cnt[6], mode_cnt[7], checked_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_integer_alu_with_flags_top OK");
    end else begin
      $display("tb_integer_alu_with_flags_top NOT OK");
    end
    $finish;
  end

endmodule
